// ===== hw/rtl/key_hash_slot_router_top_macros.svh =====
// Assertion macros used by the checker of the key hash slot router.
// No dependencies; included by the checker by bare file name.
`ifndef KEY_HASH_SLOT_ROUTER_TOP_MACROS_SVH
`define KEY_HASH_SLOT_ROUTER_TOP_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define KHSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define KHSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/khsr_pkg.sv =====
// Package of the key hash slot router: slot table constants, command codes,
// state encodings and the CRC16-XMODEM byte step. No dependencies.
package khsr_pkg;

	// Slot table geometry.
	localparam int unsigned NUM_SLOTS  = 16384;
	localparam int unsigned SLOT_BITS  = 14;
	localparam int unsigned COUNT_BITS = 15;
	localparam logic [SLOT_BITS-1:0] SLOT_MAX = SLOT_BITS'(NUM_SLOTS - 1);

	// CRC16-XMODEM constants and hash tag delimiters.
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_MSB     = 16'h8000;
	localparam logic [7:0]  OPEN_BRACE  = 8'h7B;
	localparam logic [7:0]  CLOSE_BRACE = 8'h7D;

	// Command codes carried on the kind field.
	typedef enum logic [2:0] {
		KIND_KEY_BYTE  = 3'd0,
		KIND_EMPTY_KEY = 3'd1,
		KIND_CLEAR     = 3'd2,
		KIND_FILL      = 3'd3,
		KIND_SET       = 3'd4,
		KIND_LOOKUP    = 3'd5
	} kind_t;

	// Hash tag tracker phases.
	typedef enum logic [2:0] {
		TAG_NONE   = 3'b001,
		TAG_INSIDE = 3'b010,
		TAG_CLOSED = 3'b100
	} tag_phase_t;

	// Table sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLEAR = 3'b010,
		ST_FILL  = 3'b100
	} state_t;

	// Controls from the sequencer to the key hasher.
	typedef struct packed {
		logic byte_en;
		logic restart;
	} hash_ctl_t;

	// One byte of CRC16-XMODEM, MSB first, no reflection.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/khsr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module khsr_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and read once per cycle; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/khsr_hash.sv =====
// Key hasher: running CRC16-XMODEM over the whole key and over its hash tag.
// Depends on khsr_pkg.
module khsr_hash (
	input  logic                            clk,
	input  logic                            arst_n,
	input  khsr_pkg::hash_ctl_t             ctl,
	input  logic [7:0]                      key_byte,
	input  logic                            last,
	output logic [khsr_pkg::SLOT_BITS-1:0]  slot
);

	logic [15:0]          crc_whole_q;
	logic [15:0]          crc_tag_q;
	khsr_pkg::tag_phase_t phase_q;
	logic                 nonempty_q;

	logic [15:0]          whole_nx;
	logic [15:0]          tag_upd;
	logic [15:0]          tag_nx;
	logic [15:0]          crc_sel;
	khsr_pkg::tag_phase_t phase_nx;
	logic                 nonempty_nx;

	// Next hash state for the byte on the input.
	always_comb begin
		whole_nx    = khsr_pkg::crc16_byte(crc_whole_q, key_byte);
		tag_upd     = khsr_pkg::crc16_byte(crc_tag_q, key_byte);
		tag_nx      = crc_tag_q;
		phase_nx    = phase_q;
		nonempty_nx = nonempty_q;
		unique case (phase_q)
			khsr_pkg::TAG_NONE: begin
				if (key_byte == khsr_pkg::OPEN_BRACE) begin
					phase_nx = khsr_pkg::TAG_INSIDE;
				end
			end
			khsr_pkg::TAG_INSIDE: begin
				if (key_byte == khsr_pkg::CLOSE_BRACE) begin
					phase_nx = khsr_pkg::TAG_CLOSED;
				end else begin
					tag_nx      = tag_upd;
					nonempty_nx = 1'b1;
				end
			end
			khsr_pkg::TAG_CLOSED: begin
				phase_nx = khsr_pkg::TAG_CLOSED;
			end
			default: begin
				phase_nx = khsr_pkg::TAG_NONE;
			end
		endcase
	end

	// A closed, nonempty tag selects the tag hash; otherwise the whole key.
	always_comb begin
		if (phase_nx == khsr_pkg::TAG_CLOSED && nonempty_nx) begin
			crc_sel = tag_nx;
		end else begin
			crc_sel = whole_nx;
		end
	end

	assign slot = crc_sel[khsr_pkg::SLOT_BITS-1:0];

	// Hash registers return to their start value after each key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_whole_q <= '0;
			crc_tag_q   <= '0;
			phase_q     <= khsr_pkg::TAG_NONE;
			nonempty_q  <= 1'b0;
		end else if (ctl.restart || (ctl.byte_en && last)) begin
			crc_whole_q <= '0;
			crc_tag_q   <= '0;
			phase_q     <= khsr_pkg::TAG_NONE;
			nonempty_q  <= 1'b0;
		end else if (ctl.byte_en) begin
			crc_whole_q <= whole_nx;
			crc_tag_q   <= tag_nx;
			phase_q     <= phase_nx;
			nonempty_q  <= nonempty_nx;
		end
	end

endmodule

// ===== hw/rtl/key_hash_slot_router_top.sv =====
// Top level of the key hash slot router: command sequencer and slot table.
// Depends on khsr_pkg, khsr_ram and khsr_hash.
//
//   Channel   Handshake      Payload
//   command   start / busy   kind, key_byte, last, slot_index, range_end, endpoint_id
//   result    done strobe    found, endpoint_out, slot_out, covered_count
//
// A key byte that is not last only updates the key hasher. A lookup (last key byte,
// empty key or direct) reads the slot table RAM, then shows the result on done.
// Set reads the slot, then writes it back. Fill does one read-modify-write of
// the table RAM per slot, and Clear writes every slot back to empty. After reset
// a clearing pass runs with busy high.
// Results are shown for one cycle; the receiver cannot stall them.
module key_hash_slot_router_top #(
	parameter int unsigned ENDPOINT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  key_byte,
	input  logic        last,
	input  logic [15:0] slot_index,
	input  logic [15:0] range_end,
	input  logic [7:0]  endpoint_id,
	output logic        done,
	output logic        found,
	output logic [7:0]  endpoint_out,
	output logic [13:0] slot_out,
	output logic [14:0] covered_count
);

	localparam int unsigned SB = khsr_pkg::SLOT_BITS;
	localparam int unsigned EB = ENDPOINT_BITS;

	khsr_pkg::state_t              state_q;
	logic [SB-1:0]                 addr_q;
	logic [SB-1:0]                 end_q;
	logic [EB-1:0]                 ep_q;
	logic [khsr_pkg::COUNT_BITS-1:0] covered_q;

	logic                          pend_s1;
	logic                          wr_s1;
	logic                          ok_s1;
	logic [SB-1:0]                 addr_s1;
	logic [EB-1:0]                 ep_s1;

	logic                          accept;
	logic                          s1_load;
	logic                          s1_wr_nx;
	logic                          s1_ok_nx;
	logic [SB-1:0]                 s1_addr_nx;
	logic [EB-1:0]                 s1_ep_nx;
	logic                          fill_go;
	logic [15:0]                   end_clamp;
	logic [EB+7:0]                 ep_in_ext;
	logic [EB-1:0]                 ep_in;
	logic [EB+7:0]                 ep_out_ext;

	khsr_pkg::hash_ctl_t           hash_ctl;
	logic [SB-1:0]                 key_slot;

	logic                          wr_en;
	logic [SB-1:0]                 wr_addr;
	logic [EB:0]                   wr_data;
	logic [EB:0]                   rd_data;
	logic                          rd_valid;
	logic [EB-1:0]                 rd_ep;

	// Busy while a sweep runs or a table access is in flight.
	assign busy   = (state_q != khsr_pkg::ST_IDLE) || pend_s1;
	assign accept = start && !busy;

	// Endpoint width conversions.
	assign ep_in_ext  = {{EB{1'b0}}, endpoint_id};
	assign ep_in      = ep_in_ext[EB-1:0];
	assign ep_out_ext = {8'h00, rd_ep};

	// Fill range end clamped to the last slot.
	assign end_clamp = (range_end > {{(16 - SB){1'b0}}, khsr_pkg::SLOT_MAX})
		? {{(16 - SB){1'b0}}, khsr_pkg::SLOT_MAX} : range_end;
	assign fill_go = accept && (kind == khsr_pkg::KIND_FILL) && (slot_index <= end_clamp);

	// Key hasher.
	assign hash_ctl.byte_en = accept && (kind == khsr_pkg::KIND_KEY_BYTE);
	assign hash_ctl.restart = accept && (kind == khsr_pkg::KIND_EMPTY_KEY);

	khsr_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (hash_ctl),
		.key_byte (key_byte),
		.last     (last),
		.slot     (key_slot)
	);

	// Table access issue: the read address of this cycle becomes stage one.
	always_comb begin
		s1_load    = 1'b0;
		s1_wr_nx   = 1'b0;
		s1_ok_nx   = 1'b1;
		s1_addr_nx = addr_q;
		s1_ep_nx   = ep_q;
		if (state_q == khsr_pkg::ST_FILL) begin
			s1_load  = 1'b1;
			s1_wr_nx = 1'b1;
		end else if (accept) begin
			unique case (kind)
				khsr_pkg::KIND_KEY_BYTE: begin
					s1_load    = last;
					s1_addr_nx = key_slot;
				end
				khsr_pkg::KIND_EMPTY_KEY: begin
					s1_load    = 1'b1;
					s1_addr_nx = '0;
				end
				khsr_pkg::KIND_SET: begin
					s1_load    = (slot_index[15:SB] == '0);
					s1_wr_nx   = 1'b1;
					s1_addr_nx = slot_index[SB-1:0];
					s1_ep_nx   = ep_in;
				end
				khsr_pkg::KIND_LOOKUP: begin
					s1_load    = 1'b1;
					s1_addr_nx = slot_index[SB-1:0];
					s1_ok_nx   = (slot_index[15:SB] == '0);
				end
				default: begin
					s1_load = 1'b0;
				end
			endcase
		end
	end

	// Write port: clearing sweep or write-back of stage one.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = {1'b1, ep_s1};
		if (state_q == khsr_pkg::ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = addr_q;
			wr_data = '0;
		end else if (pend_s1 && wr_s1) begin
			wr_en = 1'b1;
		end
	end

	// Slot table: valid bit over the endpoint id.
	khsr_ram #(
		.WIDTH (EB + 1),
		.DEPTH (khsr_pkg::NUM_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (s1_addr_nx),
		.rdata (rd_data)
	);

	assign rd_valid = rd_data[EB];
	assign rd_ep    = rd_data[EB-1:0];

	// Sequencer, stage-one valid and covered slot count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= khsr_pkg::ST_CLEAR;
			addr_q    <= '0;
			covered_q <= '0;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= s1_load;
			if (pend_s1 && wr_s1 && !rd_valid) begin
				covered_q <= covered_q + 1'b1;
			end
			unique case (state_q)
				khsr_pkg::ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == khsr_pkg::SLOT_MAX) begin
						state_q <= khsr_pkg::ST_IDLE;
					end
				end
				khsr_pkg::ST_FILL: begin
					if (addr_q == end_q) begin
						state_q <= khsr_pkg::ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				khsr_pkg::ST_IDLE: begin
					if (accept && kind == khsr_pkg::KIND_CLEAR) begin
						state_q   <= khsr_pkg::ST_CLEAR;
						addr_q    <= '0;
						covered_q <= '0;
					end else if (fill_go) begin
						state_q <= khsr_pkg::ST_FILL;
						addr_q  <= slot_index[SB-1:0];
					end
				end
				default: begin
					state_q <= khsr_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Payload of stage one and of the fill sweep.
	always_ff @(posedge clk) begin
		if (s1_load) begin
			wr_s1   <= s1_wr_nx;
			ok_s1   <= s1_ok_nx;
			addr_s1 <= s1_addr_nx;
			ep_s1   <= s1_ep_nx;
		end
		if (fill_go) begin
			end_q <= end_clamp[SB-1:0];
			ep_q  <= ep_in;
		end
	end

	// Result transaction, from stage one and the registered table read data.
	assign done          = pend_s1 && !wr_s1;
	assign found         = ok_s1 && rd_valid;
	assign endpoint_out  = found ? ep_out_ext[7:0] : 8'h00;
	assign slot_out      = addr_s1;
	assign covered_count = covered_q;

endmodule

// ===== hw/rtl/khsr_checker.sv =====
// Port-level checker of the key hash slot router, bound to the top level.
// Depends on khsr_pkg and key_hash_slot_router_top_macros.svh.
`include "key_hash_slot_router_top_macros.svh"

module khsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  kind,
	input logic [15:0] slot_index,
	input logic        done,
	input logic        found,
	input logic [7:0]  endpoint_out,
	input logic [14:0] covered_count
);

	// A result transaction never overlaps acceptance of a new command.
	`KHSR_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy, "result shown while idle")

	// A miss reports endpoint zero.
	`KHSR_ASSERT_SAME(a_miss_zero, clk, arst_n, done && !found, endpoint_out == 8'h00, "miss with endpoint")

	// At each result, the covered count does not exceed the table size.
	`KHSR_ASSERT_SAME(a_count_max, clk, arst_n, done, covered_count <= 15'(khsr_pkg::NUM_SLOTS), "count overflow")

	// A direct lookup answers in the next cycle.
	`KHSR_ASSERT_NEXT(a_lookup_lat, clk, arst_n, start && !busy && kind == khsr_pkg::KIND_LOOKUP, done, "lookup result late")

	// An out-of-range direct lookup misses.
	`KHSR_ASSERT_NEXT(a_lookup_oor, clk, arst_n, start && !busy && kind == khsr_pkg::KIND_LOOKUP && slot_index[15:14] != 2'b00, done && !found, "out-of-range hit")

endmodule

bind key_hash_slot_router_top khsr_checker u_khsr_checker (.*);

// ===== sim/key_hash_slot_router_checker.sv =====
`timescale 1ns / 100ps
// Checker for the key hash slot router: watches the command and result channels,
// keeps its own slot table and key hasher, and compares every lookup result.
// Depends on khsr_pkg for the command codes, table geometry and CRC constants.
module key_hash_slot_router_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  kind,
	input  logic [7:0]  key_byte,
	input  logic        last,
	input  logic [15:0] slot_index,
	input  logic [15:0] range_end,
	input  logic [7:0]  endpoint_id,
	input  logic        done,
	input  logic        found,
	input  logic [7:0]  endpoint_out,
	input  logic [13:0] slot_out,
	input  logic [14:0] covered_count,
	output int          fail_count,
	output int          pending
);

	// One expected lookup result.
	typedef struct packed {
		logic        hit;
		logic [7:0]  endpoint;
		logic [13:0] slot;
		logic [14:0] count;
	} lookup_result_t;

	lookup_result_t expected_lookups[$];

	// Shadow slot table and occupancy count.
	bit          slot_used [khsr_pkg::NUM_SLOTS];
	logic [7:0]  slot_owner [khsr_pkg::NUM_SLOTS];
	int unsigned used_slots;

	// Shadow key hasher.
	logic [15:0]          crc_all;
	logic [15:0]          crc_in_tag;
	khsr_pkg::tag_phase_t tag_state;
	logic                 tag_has_text;

	// CRC16-XMODEM, one message bit at a time, MSB first.
	function automatic logic [15:0] crc_xmodem_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        feedback;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			feedback = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (feedback ? khsr_pkg::CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic void restart_hash();
		crc_all = '0;
		crc_in_tag = '0;
		tag_state = khsr_pkg::TAG_NONE;
		tag_has_text = 1'b0;
	endfunction

	function automatic void wipe_table();
		foreach (slot_used[i]) begin
			slot_used[i] = 1'b0;
			slot_owner[i] = '0;
		end
		used_slots = 0;
	endfunction

	// Appends one expectation at the tail of the queue.
	function automatic void expect_lookup(input lookup_result_t r);
		expected_lookups.insert(expected_lookups.size(), r);
	endfunction

	// Writes beyond the table are dropped.
	function automatic void claim_slot(input int unsigned s, input logic [7:0] ep);
		if (s < khsr_pkg::NUM_SLOTS) begin
			if (!slot_used[s]) begin
				used_slots++;
			end
			slot_used[s] = 1'b1;
			slot_owner[s] = ep;
		end
	endfunction

	function automatic lookup_result_t predict_lookup(input logic [15:0] s);
		lookup_result_t r;
		r.hit = (s < khsr_pkg::NUM_SLOTS) && slot_used[s[13:0]];
		r.endpoint = r.hit ? slot_owner[s[13:0]] : 8'h00;
		r.slot = s[13:0];
		r.count = 15'(used_slots);
		return r;
	endfunction

	// Applies one accepted transaction to the shadow state.
	function automatic void apply_command();
		logic [15:0] hash;
		int unsigned lo;
		int unsigned hi;
		case (kind)
			khsr_pkg::KIND_KEY_BYTE: begin
				crc_all = crc_xmodem_step(crc_all, key_byte);
				case (tag_state)
					khsr_pkg::TAG_NONE: begin
						if (key_byte == khsr_pkg::OPEN_BRACE) begin
							tag_state = khsr_pkg::TAG_INSIDE;
						end
					end
					khsr_pkg::TAG_INSIDE: begin
						if (key_byte == khsr_pkg::CLOSE_BRACE) begin
							tag_state = khsr_pkg::TAG_CLOSED;
						end else begin
							crc_in_tag = crc_xmodem_step(crc_in_tag, key_byte);
							tag_has_text = 1'b1;
						end
					end
					default: begin
					end
				endcase
				if (last) begin
					// Only a closed, nonempty tag replaces the whole key.
					hash = (tag_state == khsr_pkg::TAG_CLOSED && tag_has_text)
						? crc_in_tag : crc_all;
					restart_hash();
					expect_lookup(predict_lookup({2'b00, hash[13:0]}));
				end
			end
			khsr_pkg::KIND_EMPTY_KEY: begin
				restart_hash();
				expect_lookup(predict_lookup(16'h0000));
			end
			khsr_pkg::KIND_CLEAR: begin
				wipe_table();
			end
			khsr_pkg::KIND_FILL: begin
				lo = slot_index;
				hi = (range_end > khsr_pkg::SLOT_MAX) ? khsr_pkg::SLOT_MAX : range_end;
				for (int unsigned s = lo; s <= hi; s++) begin
					claim_slot(s, endpoint_id);
				end
			end
			khsr_pkg::KIND_SET: begin
				claim_slot(slot_index, endpoint_id);
			end
			khsr_pkg::KIND_LOOKUP: begin
				expect_lookup(predict_lookup(slot_index));
			end
			default: begin
			end
		endcase
	endfunction

	// Compares one result against the oldest expectation.
	function automatic void check_result();
		lookup_result_t exp;
		if (expected_lookups.size() == 0) begin
			$error("unexpected result: slot_out %0d", slot_out);
			fail_count++;
		end else begin
			exp = expected_lookups.pop_front();
			if (found !== exp.hit) begin
				$error("found: expected %0d, got %0d", exp.hit, found);
				fail_count++;
			end
			if (endpoint_out !== exp.endpoint) begin
				$error("endpoint_out: expected %0d, got %0d", exp.endpoint, endpoint_out);
				fail_count++;
			end
			if (slot_out !== exp.slot) begin
				$error("slot_out: expected %0d, got %0d", exp.slot, slot_out);
				fail_count++;
			end
			if (covered_count !== exp.count) begin
				$error("covered_count: expected %0d, got %0d", exp.count, covered_count);
				fail_count++;
			end
		end
	endfunction

	// Results are checked before a new transaction is taken in at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_table();
			restart_hash();
			expected_lookups.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				check_result();
			end
			if (start && !busy) begin
				apply_command();
			end
			pending = expected_lookups.size();
		end
	end

endmodule

// ===== sim/tb_key_hash_slot_router_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the key hash slot router: clock, reset, command stimulus and verdict.
// Depends on khsr_pkg, key_hash_slot_router_top and key_hash_slot_router_checker.
module tb_key_hash_slot_router_top;

	localparam int          RANDOM_ITEMS = 1300;
	localparam int          CYCLE_LIMIT  = 1500000;
	localparam int          DRAIN_CYCLES = 10;
	localparam int          MAX_HEAVY    = 6;
	localparam logic [2:0]  KIND_SPARE_A = 3'd6;
	localparam logic [2:0]  KIND_SPARE_B = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  kind;
	logic [7:0]  key_byte;
	logic        last;
	logic [15:0] slot_index;
	logic [15:0] range_end;
	logic [7:0]  endpoint_id;
	logic        done;
	logic        found;
	logic [7:0]  endpoint_out;
	logic [13:0] slot_out;
	logic [14:0] covered_count;
	int          fail_count;
	int          pending;

	int          items_sent;
	int          no_gap_run;
	int          cycle_count;
	logic [15:0] recent_slots[$];

	key_hash_slot_router_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.key_byte     (key_byte),
		.last         (last),
		.slot_index   (slot_index),
		.range_end    (range_end),
		.endpoint_id  (endpoint_id),
		.done         (done),
		.found        (found),
		.endpoint_out (endpoint_out),
		.slot_out     (slot_out),
		.covered_count(covered_count)
	);

	key_hash_slot_router_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.key_byte     (key_byte),
		.last         (last),
		.slot_index   (slot_index),
		.range_end    (range_end),
		.endpoint_id  (endpoint_id),
		.done         (done),
		.found        (found),
		.endpoint_out (endpoint_out),
		.slot_out     (slot_out),
		.covered_count(covered_count),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] noise16();
		return 16'($urandom);
	endfunction

	// Key text without braces.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do begin
			b = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h7A));
		end while (b == khsr_pkg::OPEN_BRACE || b == khsr_pkg::CLOSE_BRACE);
		return b;
	endfunction

	// Key text with braces well represented.
	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 4))
			0: return khsr_pkg::OPEN_BRACE;
			1: return khsr_pkg::CLOSE_BRACE;
			default: return plain_byte();
		endcase
	endfunction

	// Drives one transaction at a falling edge after a random idle gap,
	// then holds it until the block accepts it.
	task automatic issue(input logic [2:0] k, input logic [7:0] b, input logic l,
		input logic [15:0] s, input logic [15:0] e, input logic [7:0] ep);
		int gap;
		if (no_gap_run == 0 && $urandom_range(0, 39) == 0) begin
			no_gap_run = $urandom_range(10, 40);
		end
		if (no_gap_run > 0) begin
			gap = 0;
			no_gap_run--;
		end else begin
			gap = $urandom_range(0, 5);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		kind <= k;
		key_byte <= b;
		last <= l;
		slot_index <= s;
		range_end <= e;
		endpoint_id <= ep;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (k != KIND_SPARE_A && k != KIND_SPARE_B) begin
			items_sent++;
		end
	endtask

	// Streams a key; the final byte carries last only when the key is to be closed.
	task automatic send_key(input string text, input bit close_key);
		for (int i = 0; i < text.len(); i++) begin
			issue(khsr_pkg::KIND_KEY_BYTE, text[i], close_key && (i == text.len() - 1),
				noise16(), noise16(), 8'($urandom));
		end
	endtask

	task automatic note_slot(input logic [15:0] s);
		recent_slots.insert(recent_slots.size(), s);
		if (recent_slots.size() > 32) begin
			void'(recent_slots.pop_front());
		end
	endtask

	// One set, small fill or direct lookup, biased toward slots written lately.
	task automatic random_table_op();
		int lo;
		int hi;
		logic [15:0] s;
		case ($urandom_range(0, 2))
			0: begin
				s = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16384, 65535))
					: 16'($urandom_range(0, 16383));
				note_slot(s);
				issue(khsr_pkg::KIND_SET, 8'($urandom), 1'($urandom), s, noise16(),
					8'($urandom));
			end
			1: begin
				lo = $urandom_range(0, 16383);
				case ($urandom_range(0, 9))
					0: begin
						lo = $urandom_range(1, 16383);
						hi = $urandom_range(0, lo - 1);
					end
					1: begin
						lo = $urandom_range(16360, 16383);
						hi = $urandom_range(16383, 65535);
					end
					default: hi = lo + $urandom_range(0, 31);
				endcase
				note_slot(16'(lo));
				issue(khsr_pkg::KIND_FILL, 8'($urandom), 1'($urandom), 16'(lo), 16'(hi),
					8'($urandom));
			end
			default: begin
				case ($urandom_range(0, 9))
					0: s = 16'($urandom_range(16384, 65535));
					1, 2, 3, 4: s = 16'($urandom_range(0, 16383));
					default: s = (recent_slots.size() > 0)
						? recent_slots[$urandom_range(0, recent_slots.size() - 1)]
						: 16'($urandom_range(0, 16383));
				endcase
				issue(khsr_pkg::KIND_LOOKUP, 8'($urandom), 1'($urandom), s, noise16(),
					8'($urandom));
			end
		endcase
	endtask

	// A random key, often shaped as prefix, tag and suffix, with table commands
	// and dropped keys now and then between its bytes.
	task automatic send_random_key();
		logic [7:0] key_text[$];
		int r;
		if ($urandom_range(0, 1) == 0) begin
			repeat ($urandom_range(0, 3)) key_text.insert(key_text.size(), plain_byte());
			key_text.insert(key_text.size(), khsr_pkg::OPEN_BRACE);
			repeat ($urandom_range(0, 4)) key_text.insert(key_text.size(), plain_byte());
			key_text.insert(key_text.size(), khsr_pkg::CLOSE_BRACE);
			repeat ($urandom_range(0, 3)) key_text.insert(key_text.size(), any_byte());
		end else begin
			repeat ($urandom_range(1, 8)) key_text.insert(key_text.size(), any_byte());
		end
		foreach (key_text[i]) begin
			r = $urandom_range(0, 99);
			if (i > 0 && r < 8) begin
				random_table_op();
			end else if (i > 0 && r < 11) begin
				issue(khsr_pkg::KIND_EMPTY_KEY, 8'($urandom), 1'($urandom), noise16(),
					noise16(), 8'($urandom));
			end
			issue(khsr_pkg::KIND_KEY_BYTE, key_text[i], i == key_text.size() - 1, noise16(),
				noise16(), 8'($urandom));
		end
	endtask

	// Stimulus: directed corner cases, then random traffic, then drain and verdict.
	initial begin
		int directed_items;
		int heavy_ops;
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		kind = khsr_pkg::KIND_KEY_BYTE;
		key_byte = '0;
		last = 1'b0;
		slot_index = '0;
		range_end = '0;
		endpoint_id = '0;
		items_sent = 0;
		no_gap_run = 0;
		heavy_ops = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Table extremes, out-of-range slots and fill corner cases.
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'd0, 16'd0, 8'h00);
		issue(khsr_pkg::KIND_SET, 8'hFF, 1'b1, 16'd0, 16'hFFFF, 8'hFF);
		issue(khsr_pkg::KIND_SET, 8'h00, 1'b0, 16'd16383, 16'h0000, 8'h00);
		issue(khsr_pkg::KIND_SET, 8'h00, 1'b0, 16'hFFFF, 16'h0000, 8'h5A);
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'd16383, 16'd0, 8'h00);
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'hFFFF, 16'd0, 8'h00);
		issue(khsr_pkg::KIND_FILL, 8'h00, 1'b0, 16'd10, 16'd20, 8'hA5);
		issue(khsr_pkg::KIND_FILL, 8'h00, 1'b0, 16'd30, 16'd25, 8'h11);
		issue(khsr_pkg::KIND_FILL, 8'h00, 1'b0, 16'd16380, 16'hFFFF, 8'h3C);
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'd15, 16'd0, 8'h00);
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'd16384, 16'd0, 8'h00);

		// A tag with a table command in the middle of the key.
		send_key("{", 1'b0);
		issue(khsr_pkg::KIND_SET, 8'h00, 1'b0, 16'd100, 16'd0, 8'h07);
		send_key("z}", 1'b1);

		// Empty tag, unclosed tag, and braces after the tag has closed.
		send_key("{}", 1'b1);
		send_key("{a", 1'b1);
		send_key("{b}}", 1'b1);

		// A key in progress dropped by an empty key.
		send_key("q", 1'b0);
		issue(khsr_pkg::KIND_EMPTY_KEY, 8'h00, 1'b0, 16'd0, 16'd0, 8'h00);

		// Clear, then confirm that the table is empty.
		issue(khsr_pkg::KIND_CLEAR, 8'h00, 1'b0, 16'd0, 16'd0, 8'h00);
		issue(khsr_pkg::KIND_LOOKUP, 8'h00, 1'b0, 16'd0, 16'd0, 8'h00);
		directed_items = items_sent;

		// Random traffic, with a few whole-table fills and clears.
		while (items_sent - directed_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_random_key();
			end else if (pick < 55) begin
				issue(khsr_pkg::KIND_EMPTY_KEY, 8'($urandom), 1'($urandom), noise16(),
					noise16(), 8'($urandom));
			end else if (pick < 95) begin
				random_table_op();
			end else if (pick < 98) begin
				issue(($urandom_range(0, 1) == 0) ? KIND_SPARE_A : KIND_SPARE_B, 8'($urandom),
					1'($urandom), noise16(), noise16(), 8'($urandom));
			end else if (heavy_ops < MAX_HEAVY) begin
				if (heavy_ops % 3 == 1) begin
					issue(khsr_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom), noise16(),
						noise16(), 8'($urandom));
				end else begin
					issue(khsr_pkg::KIND_FILL, 8'($urandom), 1'($urandom), 16'd0,
						16'($urandom_range(16383, 65535)), 8'($urandom));
				end
				heavy_ops++;
			end
		end
		start <= 1'b0;

		// Drain the outstanding lookups, then idle so that stray results can show.
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: the run must finish inside the cycle budget.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/khsr_pkg.sv
hw/rtl/khsr_ram.sv
hw/rtl/khsr_hash.sv
hw/rtl/key_hash_slot_router_top.sv
hw/rtl/khsr_checker.sv
sim/key_hash_slot_router_checker.sv
sim/tb_key_hash_slot_router_top.sv
